>>> src/chol_pkg.sv
// shared types and constants for the cholesky decomposition core
// no dependencies
package chol_pkg;

    localparam int IDX_W   = 3;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int VAL_W   = 32;
    localparam int FRAC_W  = 24;
    localparam int ACC_W   = 64;
    localparam int DIV_W   = 63;
    localparam int SIZE_W  = 4;
    localparam int ROOT_W  = 31;

    localparam logic [SIZE_W-1:0] MAX_SIZE   = 4'd8;
    localparam logic [ACC_W-1:0]  BIG_LIMIT  = 64'd1 << (2 * (VAL_W - 1) - FRAC_W);
    localparam logic [VAL_W-1:0]  VAL_MAX    = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]  VAL_MIN    = 32'h8000_0000;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_MAX,
        RES_SQRT,
        RES_DIV
    } t_res_sel;

    typedef struct packed {
        logic             rd_dot;
        logic             mul;
        logic             acc_clr;
        logic             acc_add;
        logic             rd_num;
        logic             num_ld;
        logic             sqrt_start;
        logic             div_start;
        logic             wr_res;
        t_res_sel         sel;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
        logic             last;
        logic             err;
    } t_dp_cmd;

    typedef struct packed {
        logic num_nonpos;
        logic num_big;
        logic piv_zero;
        logic sqrt_done;
        logic div_done;
    } t_dp_stat;

endpackage

>>> src/cholesky_decomposition_core.sv
// lower-triangular cholesky factoriser, signed q8.24; load items are taken only while
// idle, and the item marked last starts the run. each entry (i, j) of L runs a dot
// product and number setup, then, unless a special case gives a fixed result, a square
// root on the diagonal or a division below it, then is written and shown; the next entry
// starts when the result is taken. synchronous active-low reset; unloaded entries read as zero
module cholesky_decomposition_core
    import chol_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data,   // matrix_size
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [39:0]       i_s_tdata,       // row_index, col_index, entry_value
    input  logic              i_s_tlast,       // start_factor
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [39:0]       o_m_tdata,       // out_row, out_col, factor_value
    output logic              o_m_tuser,       // not_positive_definite
    output logic              o_m_tlast        // final_entry
);

    logic [SIZE_W-1:0] r_matrix_size;
    logic              w_in_accept;
    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [IDX_W-1:0]  w_o_row;
    logic [IDX_W-1:0]  w_o_col;
    logic [VAL_W-1:0]  w_o_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= MAX_SIZE;
        end else if (i_cfg_wr_en) begin
            r_matrix_size <= i_cfg_wr_data;
        end
    end

    assign w_in_accept = i_s_tvalid && o_s_tready;

    chol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_in_last   (i_s_tlast),
        .i_size      (r_matrix_size),
        .i_out_ready (i_m_tready),
        .i_stat      (w_stat),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .o_cmd       (w_cmd)
    );

    chol_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_in_accept),
        .i_row   (i_s_tdata[2:0]),
        .i_col   (i_s_tdata[5:3]),
        .i_value (i_s_tdata[37:6]),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_row   (w_o_row),
        .o_col   (w_o_col),
        .o_value (w_o_val),
        .o_err   (o_m_tuser),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, w_o_val, w_o_col, w_o_row};

endmodule

>>> src/chol_sqrt.sv
// iterative integer square root, two radicand bits per cycle
// depends on chol_pkg
module chol_sqrt
    import chol_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_arg,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic             r_busy;
    logic             r_done;
    logic [ACC_W-1:0] r_x;
    logic [ACC_W-1:0] r_res;
    logic [ACC_W-1:0] r_bit;
    logic [ACC_W-1:0] n_x;
    logic [ACC_W-1:0] n_res;
    logic [ACC_W-1:0] w_trial;

    always_comb begin
        w_trial = r_res + r_bit;
        if (r_x >= w_trial) begin
            n_x   = r_x - w_trial;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_x   = r_x;
            n_res = r_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == 64'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_arg;
            r_res <= '0;
            r_bit <= 64'd1 << 62;
        end else if (r_busy) begin
            r_x   <= n_x;
            r_res <= n_res;
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

>>> src/chol_div.sv
// restoring divider, one quotient bit per cycle
// depends on chol_pkg
module chol_div
    import chol_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [ROOT_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [ROOT_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_div;
    logic [DIV_W-1:0]  r_quo;
    logic [ROOT_W:0]   w_t;
    logic [ROOT_W:0]   w_diff;
    logic              w_ge;

    assign w_t    = {r_rem, r_quo[DIV_W-1]};
    assign w_diff = w_t - {1'b0, r_div};
    assign w_ge   = w_t >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[ROOT_W-1:0] : w_t[ROOT_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> src/chol_dp.sv
// datapath: covariance and factor stores, dot product, root and divide units,
// output register; depends on chol_pkg, chol_sqrt, chol_div
module chol_dp
    import chol_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [IDX_W-1:0] i_row,
    input  logic [IDX_W-1:0] i_col,
    input  logic [VAL_W-1:0] i_value,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    output logic [IDX_W-1:0] o_row,
    output logic [IDX_W-1:0] o_col,
    output logic [VAL_W-1:0] o_value,
    output logic             o_err,
    output logic             o_last
);

    logic [VAL_W-1:0]         r_cov [DEPTH];
    logic [DEPTH-1:0]         r_cov_vld;
    logic [VAL_W-1:0]         r_fac [DEPTH];
    logic [VAL_W-1:0]         r_cov_q;
    logic [VAL_W-1:0]         r_fa;
    logic [VAL_W-1:0]         r_fb;
    logic signed [ACC_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_num;
    logic signed [ACC_W-1:0]  w_rnd;
    logic [ACC_W-1:0]         w_mag;
    logic [ACC_W-1:0]         w_clamp;
    logic [ADDR_W-1:0]        w_addr_a;
    logic [ADDR_W-1:0]        w_addr_w;
    logic [ADDR_W-1:0]        w_addr_c;
    logic                     w_sqrt_done;
    logic                     w_div_done;
    logic [ROOT_W-1:0]        w_root;
    logic [DIV_W-1:0]         w_quo;
    logic [VAL_W-1:0]         w_div_val;
    logic [VAL_W-1:0]         w_res;
    logic [VAL_W-1:0]         r_o_val;
    logic [IDX_W-1:0]         r_o_row;
    logic [IDX_W-1:0]         r_o_col;
    logic                     r_o_err;
    logic                     r_o_last;

    assign w_addr_a = i_cmd.rd_dot ? {i_cmd.i, i_cmd.k} : {i_cmd.j, i_cmd.j};
    assign w_addr_w = {i_cmd.i, i_cmd.j};
    assign w_addr_c = {i_row, i_col};

    // covariance store, entries read as zero until loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cov_vld <= '0;
        end else if (i_load) begin
            r_cov_vld[w_addr_c] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cov[w_addr_c] <= i_value;
        end
        if (i_cmd.rd_num) begin
            r_cov_q <= r_cov_vld[w_addr_w] ? r_cov[w_addr_w] : '0;
        end
    end

    // factor store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_res) begin
            r_fac[w_addr_w] <= w_res;
        end
        if (i_cmd.rd_dot || i_cmd.rd_num) begin
            r_fa <= r_fac[w_addr_a];
        end
        if (i_cmd.rd_dot) begin
            r_fb <= r_fac[{i_cmd.j, i_cmd.k}];
        end
    end

    assign w_rnd = (r_prod + 64'sh80_0000) >>> FRAC_W;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= ACC_W'($signed(r_fa)) * ACC_W'($signed(r_fb));
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + w_rnd;
        end
        if (i_cmd.num_ld) begin
            r_num <= {{(ACC_W-VAL_W){r_cov_q[VAL_W-1]}}, r_cov_q} - r_acc;
        end
    end

    assign w_mag   = r_num[ACC_W-1] ? 64'(-r_num) : 64'(r_num);
    assign w_clamp = (w_mag > BIG_LIMIT) ? BIG_LIMIT : w_mag;

    assign o_stat.num_nonpos = r_num[ACC_W-1] || (r_num == '0);
    assign o_stat.num_big    = !r_num[ACC_W-1] && (64'(r_num) >= BIG_LIMIT);
    assign o_stat.piv_zero   = r_fa[VAL_W-1] || (r_fa == '0);
    assign o_stat.sqrt_done  = w_sqrt_done;
    assign o_stat.div_done   = w_div_done;

    chol_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_arg   ({2'b00, r_num[37:0], {FRAC_W{1'b0}}}),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    chol_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({w_clamp[38:0], {FRAC_W{1'b0}}}),
        .i_divisor  (r_fa[ROOT_W-1:0]),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    // saturate the quotient to the signed range
    always_comb begin
        if (r_num[ACC_W-1]) begin
            if (w_quo > 63'h8000_0000) begin
                w_div_val = VAL_MIN;
            end else begin
                w_div_val = ~w_quo[VAL_W-1:0] + 32'd1;
            end
        end else begin
            if (w_quo > 63'h7FFF_FFFF) begin
                w_div_val = VAL_MAX;
            end else begin
                w_div_val = w_quo[VAL_W-1:0];
            end
        end
    end

    always_comb begin
        case (i_cmd.sel)
            RES_ZERO: w_res = '0;
            RES_MAX:  w_res = VAL_MAX;
            RES_SQRT: w_res = {1'b0, w_root};
            RES_DIV:  w_res = w_div_val;
            default:  w_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_res) begin
            r_o_val  <= w_res;
            r_o_row  <= i_cmd.i;
            r_o_col  <= i_cmd.j;
            r_o_err  <= i_cmd.err;
            r_o_last <= i_cmd.last;
        end
    end

    assign o_row   = r_o_row;
    assign o_col   = r_o_col;
    assign o_value = r_o_val;
    assign o_err   = r_o_err;
    assign o_last  = r_o_last;

endmodule

>>> src/chol_ctrl.sv
// controller: loads, row-by-row factor sequencing and result handshake
// depends on chol_pkg
module chol_ctrl
    import chol_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_accept,
    input  logic              i_in_last,
    input  logic [SIZE_W-1:0] i_size,
    input  logic              i_out_ready,
    input  t_dp_stat          i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output t_dp_cmd           o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENTRY,
        S_DOT_RD,
        S_DOT_MUL,
        S_DOT_ACC,
        S_NUM_RD,
        S_NUM_LD,
        S_NUM_CHK,
        S_SQRT,
        S_DIV,
        S_WRITE,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_j;
    logic [IDX_W-1:0]  r_k;
    logic [SIZE_W-1:0] r_n;
    logic              r_err;
    t_res_sel          r_sel;
    logic [SIZE_W-1:0] w_n;
    logic              w_diag;
    logic              w_last;

    assign w_n    = (i_size == '0) ? SIZE_W'(1) : ((i_size > MAX_SIZE) ? MAX_SIZE : i_size);
    assign w_diag = (r_i == r_j);
    assign w_last = ({1'b0, r_i} == r_n - SIZE_W'(1)) && w_diag;

    always_comb begin
        o_cmd            = '0;
        o_cmd.i          = r_i;
        o_cmd.j          = r_j;
        o_cmd.k          = r_k;
        o_cmd.sel        = r_sel;
        o_cmd.err        = r_err;
        o_cmd.last       = w_last;
        o_cmd.acc_clr    = (r_state == S_ENTRY);
        o_cmd.rd_dot     = (r_state == S_DOT_RD);
        o_cmd.mul        = (r_state == S_DOT_MUL);
        o_cmd.acc_add    = (r_state == S_DOT_ACC);
        o_cmd.rd_num     = (r_state == S_NUM_RD);
        o_cmd.num_ld     = (r_state == S_NUM_LD);
        o_cmd.sqrt_start = (r_state == S_NUM_CHK) && w_diag
                           && !i_stat.num_nonpos && !i_stat.num_big;
        o_cmd.div_start  = (r_state == S_NUM_CHK) && !w_diag && !i_stat.piv_zero;
        o_cmd.wr_res     = (r_state == S_WRITE);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_n     <= MAX_SIZE;
            r_err   <= 1'b0;
            r_sel   <= RES_ZERO;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_accept && i_in_last) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_n     <= w_n;
                        r_err   <= 1'b0;
                        r_state <= S_ENTRY;
                    end
                end
                S_ENTRY: begin
                    r_k <= '0;
                    if (r_err) begin
                        r_sel   <= RES_ZERO;
                        r_state <= S_WRITE;
                    end else if (r_j == '0) begin
                        r_state <= S_NUM_RD;
                    end else begin
                        r_state <= S_DOT_RD;
                    end
                end
                S_DOT_RD:  r_state <= S_DOT_MUL;
                S_DOT_MUL: r_state <= S_DOT_ACC;
                S_DOT_ACC: begin
                    if (r_k == r_j - IDX_W'(1)) begin
                        r_state <= S_NUM_RD;
                    end else begin
                        r_k     <= r_k + IDX_W'(1);
                        r_state <= S_DOT_RD;
                    end
                end
                S_NUM_RD: r_state <= S_NUM_LD;
                S_NUM_LD: r_state <= S_NUM_CHK;
                S_NUM_CHK: begin
                    if (w_diag) begin
                        if (i_stat.num_nonpos) begin
                            r_err   <= 1'b1;
                            r_sel   <= RES_ZERO;
                            r_state <= S_WRITE;
                        end else if (i_stat.num_big) begin
                            r_sel   <= RES_MAX;
                            r_state <= S_WRITE;
                        end else begin
                            r_sel   <= RES_SQRT;
                            r_state <= S_SQRT;
                        end
                    end else if (i_stat.piv_zero) begin
                        r_sel   <= RES_ZERO;
                        r_state <= S_WRITE;
                    end else begin
                        r_sel   <= RES_DIV;
                        r_state <= S_DIV;
                    end
                end
                S_SQRT: begin
                    if (i_stat.sqrt_done) begin
                        r_state <= S_WRITE;
                    end
                end
                S_DIV: begin
                    if (i_stat.div_done) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_out_ready) begin
                        if (!w_diag) begin
                            r_j     <= r_j + IDX_W'(1);
                            r_state <= S_ENTRY;
                        end else if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_j     <= '0;
                            r_state <= S_ENTRY;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
